FILE: sv/assert_macros.svh
// Assertion macros shared by the date stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check, active during reset as well
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: sv/cds_pkg.sv
// Types, constants and helper functions for the calendar date stepper.
`default_nettype none

package cds_pkg;

  localparam int unsigned ActW  = 2;
  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 14;
  localparam int unsigned WdW   = 3;
  localparam int unsigned QuoW  = 8;   // year / 100 for any 14-bit year
  localparam int unsigned SumW  = 15;  // weekday sum before mod 7
  localparam int unsigned ProdW = 27;  // 14-bit year times reciprocal

  localparam logic [YearW-1:0] YearMin = 14'd1;
  localparam logic [YearW-1:0] YearMax = 14'd9999;

  // floor(y / 100) == (y * 5243) >> 19 for every y below 2**14
  localparam logic [12:0]  Div100Mul   = 13'd5243;
  localparam int unsigned  Div100Shift = 19;

  // action codes; any other code holds the date
  localparam logic [ActW-1:0] ActNext = 2'd0;
  localparam logic [ActW-1:0] ActPrev = 2'd1;

  localparam logic [MonW-1:0] MonJan = 4'd1;
  localparam logic [MonW-1:0] MonFeb = 4'd2;
  localparam logic [MonW-1:0] MonDec = 4'd12;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StRange   = 2'd2
  } status_e;

  // item after the quotient stage
  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
    logic [YearW-1:0] year_adj;  // year, less one for Jan and Feb
    logic [QuoW-1:0]  quo_y;     // year / 100
    logic [QuoW-1:0]  quo_yy;    // year_adj / 100
  } stage_t;

  // days in a month; zero for a month code outside 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (31 * mm) / 12 for the shifted month count 1..12
  function automatic logic [DayW-1:0] month_offset(input logic [MonW-1:0] mm);
    logic [DayW-1:0] off;
    unique case (mm)
      4'd1:    off = 5'd2;
      4'd2:    off = 5'd5;
      4'd3:    off = 5'd7;
      4'd4:    off = 5'd10;
      4'd5:    off = 5'd12;
      4'd6:    off = 5'd15;
      4'd7:    off = 5'd18;
      4'd8:    off = 5'd20;
      4'd9:    off = 5'd23;
      4'd10:   off = 5'd25;
      4'd11:   off = 5'd28;
      4'd12:   off = 5'd31;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

  // x mod 7 by folding octal digits (8 == 1 mod 7)
  function automatic logic [WdW-1:0] mod7(input logic [SumW-1:0] x);
    logic [5:0] fold1;
    logic [3:0] fold2;
    fold1 = {3'b0, x[2:0]} + {3'b0, x[5:3]} + {3'b0, x[8:6]}
          + {3'b0, x[11:9]} + {3'b0, x[14:12]};
    fold2 = {1'b0, fold1[5:3]} + {1'b0, fold1[2:0]};
    if (fold2 >= 4'd7) begin
      fold2 = fold2 - 4'd7;
    end
    return fold2[WdW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/calendar_date_step.sv
// Throughput: one item per clock; an accepted item passes the input register,
// the year/100 quotient stage and the result register, which form a
// three-register pipeline with no feedback; valid_o rises as the result
// register is loaded.
// busy_o is never raised and results cannot be held off by the receiver.
// Reset clears the pipeline valid bits only; no item is lost across idle.
`default_nettype none

`include "assert_macros.svh"

module calendar_date_step (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [cds_pkg::ActW-1:0]  action_i,
  input  wire logic [cds_pkg::DayW-1:0]  day_i,
  input  wire logic [cds_pkg::MonW-1:0]  month_i,
  input  wire logic [cds_pkg::YearW-1:0] year_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic [cds_pkg::DayW-1:0]      out_day_o,
  output logic [cds_pkg::MonW-1:0]      out_month_o,
  output logic [cds_pkg::YearW-1:0]     out_year_o,
  output logic [cds_pkg::WdW-1:0]       weekday_o
);
  import cds_pkg::*;

  logic   stg_valid;
  stage_t stg;
  logic   res_invalid;
  logic   res_ok;
  logic   year_in_range;

  // pipeline never stalls
  assign busy_o = 1'b0;

  cds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .action_i    (action_i),
    .day_i       (day_i),
    .month_i     (month_i),
    .year_i      (year_i),
    .stg_valid_o (stg_valid),
    .stg_o       (stg)
  );

  cds_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stg_valid_i (stg_valid),
    .stg_i       (stg),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .out_day_o   (out_day_o),
    .out_month_o (out_month_o),
    .out_year_o  (out_year_o),
    .weekday_o   (weekday_o)
  );

  // checks
  assign res_invalid   = valid_o && (status_o == StInvalid);
  assign res_ok        = valid_o && (status_o == StOk);
  assign year_in_range = (out_year_o >= YearMin) && (out_year_o <= YearMax);

  `ASSERT_CLK(a_accept_to_result, (start_i && !busy_o) |-> ##3 valid_o, "item lost in pipeline")
  `ASSERT_CLK(a_result_from_accept, valid_o |-> $past(start_i, 3), "result without item")
  `ASSERT_CLK(a_weekday_range, valid_o |-> (weekday_o <= 3'd6), "weekday out of range")
  `ASSERT_CLK(a_invalid_weekday, res_invalid |-> (weekday_o == 3'd0), "weekday on invalid date")
  `ASSERT_CLK(a_ok_year_range, res_ok |-> year_in_range, "stepped year out of range")
  `ASSERT_CLK_ALWAYS(a_no_result_in_reset, !rst_ni |-> !valid_o, "strobe during reset")

endmodule

`default_nettype wire

FILE: sv/cds_front.sv
// Input register and year/100 quotient stage of the date stepper.
`default_nettype none

module cds_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [cds_pkg::ActW-1:0]  action_i,
  input  wire logic [cds_pkg::DayW-1:0]  day_i,
  input  wire logic [cds_pkg::MonW-1:0]  month_i,
  input  wire logic [cds_pkg::YearW-1:0] year_i,
  output logic                          stg_valid_o,
  output cds_pkg::stage_t               stg_o
);
  import cds_pkg::*;

  logic             in_valid_q;
  logic [ActW-1:0]  action_q;
  logic [DayW-1:0]  day_q;
  logic [MonW-1:0]  month_q;
  logic [YearW-1:0] year_q;

  logic [YearW-1:0] year_adj;
  logic [ProdW-1:0] prod_y;
  logic [ProdW-1:0] prod_yy;
  stage_t           stg_d;
  stage_t           stg_q;
  logic             stg_valid_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      action_q <= action_i;
      day_q    <= day_i;
      month_q  <= month_i;
      year_q   <= year_i;
    end
  end

  // Jan and Feb count toward the previous year for the weekday
  assign year_adj = (month_q <= MonFeb) ? (year_q - 14'd1) : year_q;

  // divide by 100 through the reciprocal
  assign prod_y  = {13'b0, year_q}   * {14'b0, Div100Mul};
  assign prod_yy = {13'b0, year_adj} * {14'b0, Div100Mul};

  always_comb begin
    stg_d          = stg_q;
    stg_d.action   = action_q;
    stg_d.day      = day_q;
    stg_d.month    = month_q;
    stg_d.year     = year_q;
    stg_d.year_adj = year_adj;
    stg_d.quo_y    = prod_y[Div100Shift +: QuoW];
    stg_d.quo_yy   = prod_yy[Div100Shift +: QuoW];
  end

  // quotient stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      stg_q <= stg_d;
    end
  end

  assign stg_valid_o = stg_valid_q;
  assign stg_o       = stg_q;

endmodule

`default_nettype wire

FILE: sv/cds_eval.sv
// Validity check, day step and weekday, with the result register.
`default_nettype none

module cds_eval (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     stg_valid_i,
  input  wire cds_pkg::stage_t          stg_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic [cds_pkg::DayW-1:0]      out_day_o,
  output logic [cds_pkg::MonW-1:0]      out_month_o,
  output logic [cds_pkg::YearW-1:0]     out_year_o,
  output logic [cds_pkg::WdW-1:0]       weekday_o
);
  import cds_pkg::*;

  logic [SumW-1:0]  cent_y;
  logic             cent_zero;
  logic             leap;
  logic [DayW-1:0]  mlen;
  logic [DayW-1:0]  prev_len;
  logic             date_ok;
  logic [MonW-1:0]  mm;
  logic [SumW-1:0]  wd_sum;

  status_e          status_d, status_q;
  logic [DayW-1:0]  day_d, day_q;
  logic [MonW-1:0]  month_d, month_q;
  logic [YearW-1:0] year_d, year_q;
  logic [WdW-1:0]   wd_d, wd_q;
  logic             valid_q;

  // leap year: by 4 and not by 100, or by 400
  assign cent_y    = {7'b0, stg_i.quo_y} * 15'd100;
  assign cent_zero = ({1'b0, stg_i.year} == cent_y);
  assign leap      = ((stg_i.year[1:0] == 2'b00) && !cent_zero) ||
                     (cent_zero && (stg_i.quo_y[1:0] == 2'b00));

  assign mlen     = month_len(stg_i.month, leap);
  assign prev_len = month_len(stg_i.month - 4'd1, leap);

  assign date_ok = (stg_i.year >= YearMin) && (stg_i.year <= YearMax) &&
                   (stg_i.day != 5'd0) && (stg_i.day <= mlen);

  // weekday sum, March counted as month 1
  assign mm     = (stg_i.month <= MonFeb) ? (stg_i.month + 4'd10)
                                          : (stg_i.month - 4'd2);
  assign wd_sum = {10'b0, stg_i.day} + {1'b0, stg_i.year_adj}
                + {3'b0, stg_i.year_adj[YearW-1:2]} + {9'b0, stg_i.quo_yy[QuoW-1:2]}
                - {7'b0, stg_i.quo_yy} + {10'b0, month_offset(mm)};

  // step the date
  always_comb begin
    status_d = StOk;
    day_d    = stg_i.day;
    month_d  = stg_i.month;
    year_d   = stg_i.year;
    wd_d     = '0;
    if (!date_ok) begin
      status_d = StInvalid;
    end else begin
      wd_d = mod7(wd_sum);
      unique case (stg_i.action)
        ActNext: begin
          if (stg_i.day == mlen) begin
            if (stg_i.month == MonDec) begin
              if (stg_i.year >= YearMax) begin
                status_d = StRange;
              end else begin
                day_d   = 5'd1;
                month_d = MonJan;
                year_d  = stg_i.year + 14'd1;
              end
            end else begin
              day_d   = 5'd1;
              month_d = stg_i.month + 4'd1;
            end
          end else begin
            day_d = stg_i.day + 5'd1;
          end
        end
        ActPrev: begin
          if (stg_i.day == 5'd1) begin
            if (stg_i.month == MonJan) begin
              if (stg_i.year <= YearMin) begin
                status_d = StRange;
              end else begin
                day_d   = 5'd31;
                month_d = MonDec;
                year_d  = stg_i.year - 14'd1;
              end
            end else begin
              month_d = stg_i.month - 4'd1;
              day_d   = prev_len;
            end
          end else begin
            day_d = stg_i.day - 5'd1;
          end
        end
        default: begin
          // hold: date stays as it is
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stg_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_valid_i) begin
      status_q <= status_d;
      day_q    <= day_d;
      month_q  <= month_d;
      year_q   <= year_d;
      wd_q     <= wd_d;
    end
  end

  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign out_day_o   = day_q;
  assign out_month_o = month_q;
  assign out_year_o  = year_q;
  assign weekday_o   = wd_q;

endmodule

`default_nettype wire
